/* hw/rtl/wav_pcm16_mono_stream_writer_defines.svh */
// assertion macros for the wav stream writer
`ifndef WAV_PCM16_MONO_STREAM_WRITER_DEFINES_SVH
`define WAV_PCM16_MONO_STREAM_WRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wpw_pkg.sv */
// shared types and constants for the wav stream writer
package wpw_pkg;

    localparam int CfgW     = 31;
    localparam int CodeW    = 16;
    localparam int SampleW  = 24;
    localparam int HdrLen   = 44;
    localparam int IdxW     = 6;

    // register indexes
    typedef enum logic [0:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_FRAME_COUNT = 1'b1
    } t_cfg_idx;

    // one converted sample on its way to the byte sequencer
    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             hdr;
        logic             eof;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_bus;

endpackage

/* hw/rtl/wpw_front.sv */
// input register, sample conversion and file position counter
module wpw_front #(
    parameter int FRAC_BITS = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [wpw_pkg::SampleW-1:0]  i_sample,
    input  logic [wpw_pkg::CfgW-1:0]     i_frame_count,
    input  logic                         i_seq_ready,
    output wpw_pkg::t_item_bus           o_bus
);

    localparam int MagW  = (FRAC_BITS + 1 > wpw_pkg::SampleW) ? FRAC_BITS + 1 : wpw_pkg::SampleW;
    localparam int ProdW = MagW + 15;

    logic                         r_f_valid, n_f_valid;
    logic [wpw_pkg::SampleW-1:0]  r_sample;
    logic [wpw_pkg::CfgW-1:0]     r_sw, n_sw;

    logic                         accept, take, neg;
    logic [wpw_pkg::SampleW-1:0]  mag24;
    logic [MagW-1:0]              mag, one, clamped;
    logic [ProdW-1:0]             prod;
    logic [wpw_pkg::CodeW-1:0]    q, code;
    logic [wpw_pkg::CfgW-1:0]     eff, nsw;
    logic                         eof;

    assign take    = r_f_valid && i_seq_ready;
    assign o_stall = r_f_valid && !i_seq_ready;
    assign accept  = i_valid && !o_stall;

    // magnitude, clamp to one, times 32767, truncate
    always_comb begin
        neg     = r_sample[wpw_pkg::SampleW-1];
        mag24   = neg ? (~r_sample + wpw_pkg::SampleW'(1)) : r_sample;
        mag     = MagW'(mag24);
        one     = MagW'(1) << FRAC_BITS;
        clamped = (mag > one) ? one : mag;
        prod    = {clamped, 15'b0} - ProdW'(clamped);
        q       = wpw_pkg::CodeW'(prod >> FRAC_BITS);
        code    = neg ? (wpw_pkg::CodeW'(0) - q) : q;
    end

    always_comb begin
        eff = (i_frame_count == '0) ? wpw_pkg::CfgW'(1) : i_frame_count;
        nsw = r_sw + wpw_pkg::CfgW'(1);
        eof = (nsw >= eff) || (nsw == '0);
    end

    always_comb begin
        n_f_valid = r_f_valid;
        if (accept) begin
            n_f_valid = 1'b1;
        end else if (take) begin
            n_f_valid = 1'b0;
        end
        n_sw = r_sw;
        if (take) begin
            n_sw = eof ? '0 : nsw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_sw      <= '0;
        end else begin
            r_f_valid <= n_f_valid;
            r_sw      <= n_sw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
    end

    assign o_bus.valid     = r_f_valid;
    assign o_bus.item.code = code;
    assign o_bus.item.hdr  = (r_sw == '0);
    assign o_bus.item.eof  = eof;

endmodule

/* hw/rtl/wpw_seq.sv */
// byte sequencer: header bytes, sample bytes and the output register
module wpw_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  wpw_pkg::t_item_bus       i_bus,
    output logic                     o_ready,
    input  logic [wpw_pkg::CfgW-1:0] i_rate_hz,
    input  logic [wpw_pkg::CfgW-1:0] i_frame_count,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [7:0]               o_out_byte,
    output logic                     o_last_of_run,
    output logic                     o_end_of_file
);

    localparam logic [wpw_pkg::IdxW-1:0] IdxLow  = wpw_pkg::IdxW'(wpw_pkg::HdrLen);
    localparam logic [wpw_pkg::IdxW-1:0] IdxHigh = wpw_pkg::IdxW'(wpw_pkg::HdrLen + 1);

    // header words, little-endian byte order
    localparam logic [31:0] WordRiff = 32'h4646_4952;
    localparam logic [31:0] WordWave = 32'h4556_4157;
    localparam logic [31:0] WordFmt  = 32'h2074_6D66;
    localparam logic [31:0] WordData = 32'h6174_6164;
    localparam logic [31:0] WordFmtLen   = 32'd16;
    localparam logic [31:0] WordPcmMono  = 32'h0001_0001;
    localparam logic [31:0] WordAlignBps = 32'h0010_0002;

    logic                      r_s_valid, n_s_valid;
    wpw_pkg::t_item            r_item;
    logic [wpw_pkg::IdxW-1:0]  r_idx, n_idx;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_byte;
    logic                      r_last, r_eof;

    logic                      out_free, emit, done, load;
    logic [wpw_pkg::CfgW-1:0]  eff;
    logic [31:0]               payload_len, riff_size, bytes_per_sec, word;
    logic [7:0]                hdr_byte, cur_byte;
    logic                      cur_last, cur_eof;

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_s_valid && out_free;
    assign done     = emit && (r_idx == IdxHigh);
    assign o_ready  = !r_s_valid || done;
    assign load     = i_bus.valid && o_ready;

    always_comb begin
        eff           = (i_frame_count == '0) ? wpw_pkg::CfgW'(1) : i_frame_count;
        payload_len   = {eff, 1'b0};
        riff_size     = payload_len + 32'd36;
        bytes_per_sec = {i_rate_hz, 1'b0};
        unique case (r_idx[5:2])
            4'd0:    word = WordRiff;
            4'd1:    word = riff_size;
            4'd2:    word = WordWave;
            4'd3:    word = WordFmt;
            4'd4:    word = WordFmtLen;
            4'd5:    word = WordPcmMono;
            4'd6:    word = {1'b0, i_rate_hz};
            4'd7:    word = bytes_per_sec;
            4'd8:    word = WordAlignBps;
            4'd9:    word = WordData;
            4'd10:   word = payload_len;
            default: word = '0;
        endcase
        hdr_byte = word[8*r_idx[1:0] +: 8];
    end

    always_comb begin
        cur_last = 1'b0;
        cur_eof  = 1'b0;
        if (r_idx == IdxHigh) begin
            cur_byte = r_item.code[15:8];
            cur_last = 1'b1;
            cur_eof  = r_item.eof;
        end else if (r_idx == IdxLow) begin
            cur_byte = r_item.code[7:0];
        end else begin
            cur_byte = hdr_byte;
        end
    end

    always_comb begin
        n_s_valid = r_s_valid;
        n_idx     = r_idx;
        if (load) begin
            n_s_valid = 1'b1;
            n_idx     = i_bus.item.hdr ? '0 : IdxLow;
        end else if (done) begin
            n_s_valid = 1'b0;
        end else if (emit) begin
            n_idx = r_idx + wpw_pkg::IdxW'(1);
        end
        n_out_valid = out_free ? emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s_valid   <= n_s_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_bus.item;
        end
        if (emit) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
            r_eof  <= cur_eof;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_end_of_file = r_eof;

endmodule

/* hw/rtl/wav_pcm16_mono_stream_writer.sv */
// wav stream writer top level: config registers, front end and byte sequencer
// Turns mono samples into the byte stream of canonical 16-bit PCM WAV files.
// Input channel: i_valid/o_stall with i_sample (signed, INPUT_FRAC_BITS fraction
// bits). Output channel: o_valid/i_stall with one file byte per beat, flagged
// with o_last_of_run on the last byte of a sample and o_end_of_file on the last
// byte of a file. Config channel: i_cfg_valid/o_cfg_ready (always ready),
// index 0 is the sample rate, index 1 is frame_count.
// Each sample gives two bytes; the first sample of a file is preceded by the
// 44 header bytes, so it gives 46 bytes. The output side moves one byte per
// cycle while i_stall is low. An accepted sample passes through the input
// register, the sequencer's item register and the output byte register.
// A sample sits in the input register while the previous one is serialized,
// so the next sample is taken while bytes are still going out.
// Reset clears all valids and the file position, and loads a sample rate of
// 48000 and frame_count 1. A stall on the output holds the byte in place; the
// sequencer and then the input register fill and o_stall rises.
`include "wav_pcm16_mono_stream_writer_defines.svh"

module wav_pcm16_mono_stream_writer #(
    parameter int INPUT_FRAC_BITS = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [wpw_pkg::SampleW-1:0]  i_sample,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last_of_run,
    output logic                         o_end_of_file,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [0:0]                   i_cfg_index,
    input  logic [wpw_pkg::CfgW-1:0]     i_cfg_data
);

    logic [wpw_pkg::CfgW-1:0] r_rate_hz, r_frame_count;
    logic                     cfg_wr, seq_ready;
    wpw_pkg::t_item_bus       item_bus;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_hz     <= wpw_pkg::CfgW'(48000);
            r_frame_count <= wpw_pkg::CfgW'(1);
        end else if (cfg_wr) begin
            unique case (wpw_pkg::t_cfg_idx'(i_cfg_index))
                wpw_pkg::CFG_SAMPLE_RATE: r_rate_hz     <= i_cfg_data;
                wpw_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wpw_front #(
        .FRAC_BITS (INPUT_FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_frame_count (r_frame_count),
        .i_seq_ready   (seq_ready),
        .o_bus         (item_bus)
    );

    wpw_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bus         (item_bus),
        .o_ready       (seq_ready),
        .i_rate_hz     (r_rate_hz),
        .i_frame_count (r_frame_count),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_end_of_file (o_end_of_file)
    );

    `WPW_ASSERT_NOW(a_eof_is_last, i_clk, i_rst_n, o_valid && o_end_of_file, o_last_of_run, "end of file on a byte that is not the last of its sample")
    `WPW_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, o_stall, item_bus.valid && !seq_ready, "input stalled with no item blocked in the front end")
    `WPW_ASSERT_NEXT(a_take_frees_front, i_clk, i_rst_n, item_bus.valid && seq_ready && !(i_valid && !o_stall), !item_bus.valid, "front end item not released after hand-off")

endmodule
